/* hw/rtl/pssp_pkg.sv */
package pssp_pkg;

    localparam int AXES = 4;
    localparam int COEF_W = 64;
    localparam int WHOLE_W = 32;
    localparam int COUNT_W = 32;
    localparam int INDEX_W = 12;
    localparam int STEP_W = AXES;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        COEF_POSITION = 2'd0,
        COEF_RATE     = 2'd1,
        COEF_ACCEL    = 2'd2,
        COEF_JERK     = 2'd3
    } coef_sel_t;

    // State of one axis: the four polynomial terms and the last whole position.
    typedef struct packed {
        logic [COEF_W-1:0]  jerk;
        logic [COEF_W-1:0]  accel;
        logic [COEF_W-1:0]  rate;
        logic [COEF_W-1:0]  position;
        logic [WHOLE_W-1:0] last_whole;
    } axis_state_t;

    typedef struct packed {
        axis_state_t [AXES-1:0] axis;
    } state_row_t;

endpackage

/* hw/rtl/poly_segment_step_pulse_generator.sv */
// Four-axis step pulse generator driven by forward differencing of a cubic in
// 32.32 fixed point. Beats on the input carry a kind in s_axis_tuser: load one
// coefficient, start a segment, or advance one tick. Each tick of an armed
// segment produces one output beat with the step pattern and tick index, and
// tlast marks the final tick; loads, starts, unused kinds and ticks beyond the
// segment produce nothing. The block takes one beat per cycle, and a result
// passes through the stage 1 item and then the output register. All axis
// state sits in one state RAM row read through a registered port; the row
// written by a beat is forwarded to the beat right behind it, so back-to-back
// beats never wait. Only backpressure on the output stalls the input.
module poly_segment_step_pulse_generator import pssp_pkg::*; #(
    parameter int MAX_TICKS = 4096
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [1:0] axis_select, [3:2] coefficient_select, [67:4] coefficient_value,
    // [99:68] tick_count, [103:100] zero
    input  logic [103:0] s_axis_tdata,
    // [1:0] opcode
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [3:0] step_pattern, [15:4] tick_index
    output logic [15:0]  m_axis_tdata,
    output logic         m_axis_tlast
);

    localparam int REM_W = $clog2(MAX_TICKS + 1);
    localparam logic [COUNT_W-1:0] MaxTicks = COUNT_W'(MAX_TICKS);

    // Stage 1 item.
    logic               s1_valid_reg;
    opcode_t            s1_op_reg;
    logic [1:0]         s1_axis_reg;
    coef_sel_t          s1_coef_reg;
    logic [COEF_W-1:0]  s1_value_reg;
    logic [COUNT_W-1:0] s1_count_reg;

    // State RAM row, its registered read port and the write-back forward path.
    state_row_t         state_mem;
    state_row_t         rd_row_reg;
    state_row_t         wr_row_reg;
    logic               fwd_valid_reg;

    logic [REM_W-1:0]   ticks_rem_reg, ticks_rem_next;
    logic [INDEX_W-1:0] tick_cnt_reg, tick_cnt_next;

    logic               m_valid_reg;
    logic [STEP_W-1:0]  m_step_reg;
    logic [INDEX_W-1:0] m_index_reg;
    logic               m_last_reg;

    state_row_t         cur_row;
    state_row_t         tick_row;
    state_row_t         row_next;
    logic [STEP_W-1:0]  step_bits;
    logic               s1_fire;
    logic               tick_live;
    logic               in_fire;

    assign s1_fire       = s1_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_fire;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cur_row       = fwd_valid_reg ? wr_row_reg : rd_row_reg;
    assign tick_live     = (s1_op_reg == OP_TICK) && (ticks_rem_reg != '0);

    for (genvar a = 0; a < AXES; a++) begin : g_axis
        pssp_axis_step u_step (
            .cur     (cur_row.axis[a]),
            .tick_en (tick_live),
            .nxt     (tick_row.axis[a]),
            .step    (step_bits[a])
        );
    end

    always_comb begin
        row_next       = tick_row;
        ticks_rem_next = ticks_rem_reg;
        tick_cnt_next  = tick_cnt_reg;
        unique case (s1_op_reg)
            OP_LOAD: begin
                unique case (s1_coef_reg)
                    COEF_POSITION: row_next.axis[s1_axis_reg].position = s1_value_reg;
                    COEF_RATE:     row_next.axis[s1_axis_reg].rate     = s1_value_reg;
                    COEF_ACCEL:    row_next.axis[s1_axis_reg].accel    = s1_value_reg;
                    COEF_JERK:     row_next.axis[s1_axis_reg].jerk     = s1_value_reg;
                    default:       row_next = tick_row;
                endcase
            end
            OP_START: begin
                for (int a = 0; a < AXES; a++) begin
                    row_next.axis[a].last_whole = '0;
                end
                ticks_rem_next = (s1_count_reg > MaxTicks) ? REM_W'(MAX_TICKS)
                                                           : REM_W'(s1_count_reg);
                tick_cnt_next  = '0;
            end
            OP_TICK: begin
                if (tick_live) begin
                    ticks_rem_next = ticks_rem_reg - REM_W'(1);
                    tick_cnt_next  = tick_cnt_reg + INDEX_W'(1);
                end
            end
            default: row_next = tick_row;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            ticks_rem_reg <= '0;
            tick_cnt_reg  <= '0;
            state_mem     <= '0;
            rd_row_reg    <= '0;
        end else begin
            rd_row_reg    <= state_mem;
            fwd_valid_reg <= s1_fire;
            if (in_fire) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_fire) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire) begin
                state_mem     <= row_next;
                ticks_rem_reg <= ticks_rem_next;
                tick_cnt_reg  <= tick_cnt_next;
            end
            if (s1_fire && tick_live) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            s1_op_reg    <= opcode_t'(s_axis_tuser);
            s1_axis_reg  <= s_axis_tdata[1:0];
            s1_coef_reg  <= coef_sel_t'(s_axis_tdata[3:2]);
            s1_value_reg <= s_axis_tdata[67:4];
            s1_count_reg <= s_axis_tdata[99:68];
        end
        if (s1_fire) begin
            wr_row_reg <= row_next;
        end
        if (s1_fire && tick_live) begin
            m_step_reg  <= step_bits;
            m_index_reg <= tick_cnt_reg;
            m_last_reg  <= (ticks_rem_reg == REM_W'(1));
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_index_reg, m_step_reg};
    assign m_axis_tlast  = m_last_reg;

endmodule

/* hw/rtl/pssp_axis_step.sv */
module pssp_axis_step import pssp_pkg::*; (
    input  axis_state_t cur,
    input  logic        tick_en,
    output axis_state_t nxt,
    output logic        step
);

    logic [WHOLE_W-1:0] whole;

    assign whole = cur.position[COEF_W-1:COEF_W-WHOLE_W];

    always_comb begin
        step = tick_en && ($signed(whole) > $signed(cur.last_whole));
        nxt = cur;
        if (tick_en) begin
            if (step) begin
                nxt.last_whole = whole;
            end
            // Forward differencing; every sum wraps modulo 2^64.
            nxt.position = cur.position + cur.rate;
            nxt.rate     = cur.rate + cur.accel;
            nxt.accel    = cur.accel + cur.jerk;
        end
    end

endmodule
